/* hdl/art_pkg.sv */
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the address region table: commands, status
// codes, controller states and the controller to datapath signal groups.
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int PAGE_SHIFT    = 12;
	localparam int VIRT_BITS     = 32;

	localparam int VA_W   = 32;
	localparam int PA_W   = 64;
	localparam int LEN_W  = 32;
	localparam int FL_W   = 32;
	localparam int LIM_W  = 33;
	localparam int VPG_W  = VA_W - PAGE_SHIFT;
	localparam int EPG_W  = VPG_W + 1;
	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int S_DATA_W = 168;
	localparam int M_DATA_W = 104;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 33;

	localparam logic [CFG_IDX_W-1:0] REG_USER_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_USER_LIMIT = 1'b1;

	localparam logic [VA_W-1:0]  USER_BASE_RST  = 32'h0040_0000;
	localparam logic [LIM_W-1:0] USER_LIMIT_RST = 33'h0_C000_0000;

	localparam logic [VA_W-1:0]  VA_PAGE_MASK = VA_W'((64'd1 << PAGE_SHIFT) - 64'd1);
	localparam logic [PA_W-1:0]  PA_PAGE_MASK = PA_W'((64'd1 << PAGE_SHIFT) - 64'd1);
	localparam logic [48:0]      VA_END_MAX   = 49'd1 << VIRT_BITS;

	typedef enum logic [1:0] {
		CMD_MAP     = 2'd0,
		CMD_UNMAP   = 2'd1,
		CMD_PROTECT = 2'd2,
		CMD_FIND    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_EXISTS  = 3'd2,
		ST_NOENT   = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic             load;
		logic             check;
		logic             scan;
		logic [IDX_W-1:0] idx;
		logic             finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic bad;
		logic out_free;
	} dp_sts_t;

endpackage

/* hdl/art_ctrl.sv */
// ----------------------------------------------------------------------------
// art_ctrl
// Command sequencer: takes a transfer, runs the range check, walks the table
// one entry per cycle unless the check fails, and hands the result to the output register.
// ----------------------------------------------------------------------------
module art_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  art_pkg::dp_sts_t  sts,
	output art_pkg::ctl_cmd_t cmd
);

	art_pkg::state_t              state_q, state_nxt;
	logic [art_pkg::IDX_W-1:0]    idx_q;
	logic                         idx_last;

	assign idx_last = (idx_q == art_pkg::IDX_W'(art_pkg::TABLE_ENTRIES - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			art_pkg::S_IDLE: begin
				if (s_tvalid) state_nxt = art_pkg::S_CHECK;
			end
			art_pkg::S_CHECK: begin
				state_nxt = sts.bad ? art_pkg::S_FINISH : art_pkg::S_SCAN;
			end
			art_pkg::S_SCAN: begin
				if (idx_last) state_nxt = art_pkg::S_FINISH;
			end
			art_pkg::S_FINISH: begin
				if (sts.out_free) state_nxt = art_pkg::S_IDLE;
			end
			default: state_nxt = art_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.check  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.idx    = idx_q;
		cmd.finish = 1'b0;
		unique case (state_q)
			art_pkg::S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			art_pkg::S_CHECK:  cmd.check = 1'b1;
			art_pkg::S_SCAN:   cmd.scan = 1'b1;
			art_pkg::S_FINISH: cmd.finish = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= art_pkg::S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == art_pkg::S_SCAN) idx_q <= idx_last ? '0 : idx_q + 1'b1;
			else idx_q <= '0;
		end
	end

endmodule

/* hdl/art_dp.sv */
// ----------------------------------------------------------------------------
// art_dp
// Datapath: configuration registers, command registers, range checks, the
// region table with its scan flags, and the result register.
// ----------------------------------------------------------------------------
module art_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [art_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [art_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [art_pkg::S_DATA_W-1:0]     s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [art_pkg::M_DATA_W-1:0]     m_tdata,
	input  art_pkg::ctl_cmd_t                cmd,
	output art_pkg::dp_sts_t                 sts
);

	// configuration
	logic [art_pkg::VA_W-1:0]  base_q;
	logic [art_pkg::LIM_W-1:0] lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= art_pkg::USER_BASE_RST;
			lim_q  <= art_pkg::USER_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				art_pkg::REG_USER_BASE:  base_q <= cfg_data[art_pkg::VA_W-1:0];
				art_pkg::REG_USER_LIMIT: lim_q  <= cfg_data[art_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// command registers
	art_pkg::cmd_t              op_q;
	logic [art_pkg::VA_W-1:0]   va_q;
	logic [art_pkg::PA_W-1:0]   pa_q;
	logic [art_pkg::LEN_W-1:0]  len_q;
	logic [art_pkg::FL_W-1:0]   fl_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= art_pkg::cmd_t'(s_tdata[1:0]);
			va_q  <= s_tdata[33:2];
			pa_q  <= s_tdata[97:34];
			len_q <= s_tdata[129:98];
			fl_q  <= s_tdata[161:130];
		end
	end

	// range checks
	logic [art_pkg::LIM_W-1:0] end_w;
	logic [art_pkg::PA_W:0]    pa_sum;
	logic                      misal, range_bad, pwrap, lim_ok;

	assign end_w  = {1'b0, va_q} + {1'b0, len_q};
	assign pa_sum = {1'b0, pa_q} + (art_pkg::PA_W + 1)'(len_q - 1'b1);
	assign misal  = ((va_q & art_pkg::VA_PAGE_MASK) != '0)
		|| ((len_q & art_pkg::VA_PAGE_MASK) != '0)
		|| (op_q == art_pkg::CMD_MAP && (pa_q & art_pkg::PA_PAGE_MASK) != '0);
	assign lim_ok = ({1'b0, va_q} < lim_q);
	assign range_bad = (va_q < base_q) || !lim_ok
		|| (49'(end_w) > art_pkg::VA_END_MAX) || (end_w > lim_q);
	assign pwrap  = (op_q == art_pkg::CMD_MAP) && pa_sum[art_pkg::PA_W];
	assign sts.bad = (op_q != art_pkg::CMD_FIND)
		&& ((len_q == '0) || misal || range_bad || pwrap);

	logic                       inv_q, lim_ok_q;
	logic [art_pkg::VPG_W-1:0]  vpg_q;
	logic [art_pkg::EPG_W-1:0]  epg_q;

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			inv_q    <= sts.bad;
			lim_ok_q <= lim_ok;
			vpg_q    <= va_q[art_pkg::VA_W-1:art_pkg::PAGE_SHIFT];
			epg_q    <= end_w[art_pkg::LIM_W-1:art_pkg::PAGE_SHIFT];
		end
	end

	// region table
	logic [art_pkg::TABLE_ENTRIES-1:0] valid_q;
	logic [art_pkg::VPG_W-1:0]         spg_q [art_pkg::TABLE_ENTRIES];
	logic [art_pkg::EPG_W-1:0]         rpg_q [art_pkg::TABLE_ENTRIES];
	logic [art_pkg::FL_W-1:0]          rfl_q [art_pkg::TABLE_ENTRIES];

	// scan of one entry per cycle
	logic                      rd_v, hit, ovl;
	logic [art_pkg::VPG_W-1:0] rd_s;
	logic [art_pkg::EPG_W-1:0] rd_e;

	assign rd_v = valid_q[cmd.idx];
	assign rd_s = spg_q[cmd.idx];
	assign rd_e = rpg_q[cmd.idx];
	assign hit  = rd_v && (rd_s <= vpg_q) && ((op_q == art_pkg::CMD_FIND)
		? ({1'b0, vpg_q} < rd_e) : (epg_q <= rd_e));
	assign ovl  = rd_v && (rd_e > {1'b0, vpg_q}) && ({1'b0, rd_s} < epg_q);

	logic                      hit_f_q, exact_q, ovl_f_q, free_f_q;
	logic [art_pkg::IDX_W-1:0] hit_idx_q, free_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			hit_f_q  <= 1'b0;
			ovl_f_q  <= 1'b0;
			free_f_q <= 1'b0;
		end else if (cmd.scan) begin
			if (hit && !hit_f_q) begin
				hit_f_q   <= 1'b1;
				hit_idx_q <= cmd.idx;
				exact_q   <= (rd_s == vpg_q) && (rd_e == epg_q);
			end
			if (ovl) ovl_f_q <= 1'b1;
			if (!rd_v && !free_f_q) begin
				free_f_q   <= 1'b1;
				free_idx_q <= cmd.idx;
			end
		end
	end

	// result and table update
	art_pkg::status_t           res_st;
	logic                       res_found, wr_map, wr_unmap, wr_prot;

	always_comb begin
		res_st    = art_pkg::ST_OK;
		res_found = 1'b0;
		wr_map    = 1'b0;
		wr_unmap  = 1'b0;
		wr_prot   = 1'b0;
		priority if (op_q == art_pkg::CMD_FIND) begin
			if (lim_ok_q && hit_f_q) res_found = 1'b1;
			else res_st = art_pkg::ST_NOENT;
		end else if (inv_q) begin
			res_st = art_pkg::ST_INVALID;
		end else if (op_q == art_pkg::CMD_MAP) begin
			priority if (ovl_f_q) res_st = art_pkg::ST_EXISTS;
			else if (!free_f_q) res_st = art_pkg::ST_FULL;
			else wr_map = cmd.finish;
		end else begin
			priority if (!hit_f_q) res_st = art_pkg::ST_NOENT;
			else if (!exact_q) res_st = art_pkg::ST_INVALID;
			else if (op_q == art_pkg::CMD_UNMAP) wr_unmap = cmd.finish;
			else wr_prot = cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_map) begin
			spg_q[free_idx_q] <= vpg_q;
			rpg_q[free_idx_q] <= epg_q;
		end
		if (wr_map || wr_prot) rfl_q[wr_map ? free_idx_q : hit_idx_q] <= fl_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (wr_map) valid_q[free_idx_q] <= 1'b1;
			if (wr_unmap) valid_q[hit_idx_q] <= 1'b0;
		end
	end

	// output register
	logic                      m_valid_q;
	art_pkg::status_t          o_st_q;
	logic                      o_found_q;
	logic [art_pkg::VA_W-1:0]  o_base_q;
	logic [art_pkg::LIM_W-1:0] o_lim_q;
	logic [art_pkg::FL_W-1:0]  o_fl_q;

	assign sts.out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			o_st_q    <= res_st;
			o_found_q <= res_found;
			o_base_q  <= res_found
				? art_pkg::VA_W'(spg_q[hit_idx_q]) << art_pkg::PAGE_SHIFT : '0;
			o_lim_q   <= res_found
				? art_pkg::LIM_W'(rpg_q[hit_idx_q]) << art_pkg::PAGE_SHIFT : '0;
			o_fl_q    <= res_found ? rfl_q[hit_idx_q] : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, o_fl_q, o_lim_q, o_base_q, o_found_q, o_st_q};

	a_map_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr_map |-> !valid_q[free_idx_q])
		else $error("map into an occupied slot");

	a_map_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_map |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
		else $error("map did not add one region");

	a_unmap_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		wr_unmap |=> $countones(valid_q) + 1 == $past($countones(valid_q)))
		else $error("unmap did not remove one region");

	a_find_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && op_q == art_pkg::CMD_FIND) |-> !(wr_map || wr_unmap || wr_prot))
		else $error("find changed the table");

endmodule

/* hdl/address_region_table.sv */
// ----------------------------------------------------------------------------
// address_region_table
// Table of page-aligned address regions with map, unmap, protect and find.
// ----------------------------------------------------------------------------
// One command at a time. A command passes from its input transfer to its
// result through a range check, a walk over the sixteen table entries (one
// entry per cycle through a single read port) and a final step that updates
// the table and loads the result register. The block then returns to idle,
// and only there takes the next command. A map, unmap or protect that fails
// the range checks skips the walk. The next command is taken while a result
// still waits on the output; its own result is held until the waiting one
// has left. Valid marks are cleared at reset, so no clearing pass is needed.
module address_region_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [art_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [art_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// command[1:0], address[33:2], phys_address[97:34], length[129:98],
	// flags[161:130], zero fill
	input  logic [art_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status[2:0], found[3], region_base[35:4], region_limit[68:36],
	// region_flags[100:69], zero fill
	output logic [art_pkg::M_DATA_W-1:0]   m_tdata
);

	art_pkg::ctl_cmd_t ctl_cmd;
	art_pkg::dp_sts_t  dp_sts;

	art_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	art_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (ctl_cmd),
		.sts       (dp_sts)
	);

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams map, unmap, protect and find commands into the address region
// table and checks every reply against a shadow copy of the region table.
// Random idle bursts fall on both sides of the block, and two long output
// hold-offs back the block up. The user range registers are rewritten
// between phases, including the inverted and widest settings.
// ----------------------------------------------------------------------------
module testbench;

	localparam bit [63:0] PAGE_BYTE_MASK = (64'd1 << art_pkg::PAGE_SHIFT) - 64'd1;
	localparam bit [63:0] VA_TOP         = (64'd1 << art_pkg::VIRT_BITS) - 64'd1;

	typedef struct {
		art_pkg::cmd_t command;
		bit [31:0]     address;
		bit [63:0]     phys_address;
		bit [31:0]     length;
		bit [31:0]     flags;
	} region_request_t;

	typedef struct {
		art_pkg::status_t status;
		bit               found;
		bit [31:0]        base;
		bit [32:0]        limit;
		bit [31:0]        flags;
	} region_reply_t;

	typedef struct {
		bit [31:0]   base_addr;
		bit [31:0]   span_len;
	} span_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [art_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [art_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [art_pkg::S_DATA_W-1:0]   s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [art_pkg::M_DATA_W-1:0]   m_tdata;

	region_request_t command_queue[$];
	region_reply_t   awaited_replies[$];
	span_t           mapped_spans[$];
	region_request_t offered;
	region_reply_t   oldest_reply;

	bit [31:0]               model_user_base = art_pkg::USER_BASE_RST;
	bit [32:0]               model_user_limit = art_pkg::USER_LIMIT_RST;
	bit                      shadow_valid [art_pkg::TABLE_ENTRIES];
	bit [art_pkg::VPG_W-1:0] shadow_start_page [art_pkg::TABLE_ENTRIES];
	bit [art_pkg::EPG_W-1:0] shadow_end_page [art_pkg::TABLE_ENTRIES];
	bit [31:0]               shadow_flags [art_pkg::TABLE_ENTRIES];

	bit [31:0]       window_origin = 32'h0040_0000;
	bit [31:0]       window_alt = 32'hBFF0_0000;
	int              idle_pct = 20;
	bit              calm = 1'b0;
	int              send_gap = 0;
	int              stall_left = 0;
	int              hold_left = 0;
	int              replies_seen = 0;
	int              mismatch_count = 0;

	address_region_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit [63:0] region_start(int i);
		return 64'(shadow_start_page[i]) << art_pkg::PAGE_SHIFT;
	endfunction

	function automatic bit [63:0] region_end(int i);
		return 64'(shadow_end_page[i]) << art_pkg::PAGE_SHIFT;
	endfunction

	function automatic region_reply_t apply_command(region_request_t rq);
		region_reply_t rp;
		bit [63:0] va;
		bit [63:0] len;
		bit [63:0] va_end;
		int hit;
		int slot;
		rp.status = art_pkg::ST_OK;
		rp.found = 1'b0;
		rp.base = '0;
		rp.limit = '0;
		rp.flags = '0;
		va = 64'(rq.address);
		len = 64'(rq.length);
		va_end = va + len;
		hit = -1;
		slot = -1;
		if (rq.command == art_pkg::CMD_FIND) begin
			if (va < 64'(model_user_limit))
				for (int i = 0; i < art_pkg::TABLE_ENTRIES; i++)
					if (hit < 0 && shadow_valid[i] && region_start(i) <= va
							&& va < region_end(i))
						hit = i;
			if (hit < 0) begin
				rp.status = art_pkg::ST_NOENT;
			end else begin
				rp.found = 1'b1;
				rp.base = 32'(region_start(hit));
				rp.limit = 33'(region_end(hit));
				rp.flags = shadow_flags[hit];
			end
		end else if (len == 0 || (va & PAGE_BYTE_MASK) != 0 || (len & PAGE_BYTE_MASK) != 0
				|| (rq.command == art_pkg::CMD_MAP
					&& (rq.phys_address & PAGE_BYTE_MASK) != 0)
				|| va < 64'(model_user_base) || va >= 64'(model_user_limit)
				|| va_end - 64'd1 > VA_TOP || va_end > 64'(model_user_limit)) begin
			rp.status = art_pkg::ST_INVALID;
		end else if (rq.command == art_pkg::CMD_MAP) begin
			if (len - 64'd1 > ~rq.phys_address) begin
				rp.status = art_pkg::ST_INVALID;
			end else begin
				for (int i = 0; i < art_pkg::TABLE_ENTRIES; i++)
					if (shadow_valid[i] && region_end(i) > va && region_start(i) < va_end)
						rp.status = art_pkg::ST_EXISTS;
				if (rp.status == art_pkg::ST_OK) begin
					for (int i = 0; i < art_pkg::TABLE_ENTRIES; i++)
						if (slot < 0 && !shadow_valid[i])
							slot = i;
					if (slot < 0) begin
						rp.status = art_pkg::ST_FULL;
					end else begin
						shadow_valid[slot] = 1'b1;
						shadow_start_page[slot] =
							art_pkg::VPG_W'(va >> art_pkg::PAGE_SHIFT);
						shadow_end_page[slot] =
							art_pkg::EPG_W'(va_end >> art_pkg::PAGE_SHIFT);
						shadow_flags[slot] = rq.flags;
					end
				end
			end
		end else begin
			for (int i = 0; i < art_pkg::TABLE_ENTRIES; i++)
				if (hit < 0 && shadow_valid[i] && region_start(i) <= va
						&& va_end <= region_end(i))
					hit = i;
			if (hit < 0)
				rp.status = art_pkg::ST_NOENT;
			else if (region_start(hit) != va || region_end(hit) != va_end)
				rp.status = art_pkg::ST_INVALID;
			else if (rq.command == art_pkg::CMD_UNMAP)
				shadow_valid[hit] = 1'b0;
			else
				shadow_flags[hit] = rq.flags;
		end
		return rp;
	endfunction

	function automatic void push_command(art_pkg::cmd_t command, bit [31:0] address,
			bit [63:0] phys_address, bit [31:0] length, bit [31:0] flags);
		region_request_t rq;
		rq.command = command;
		rq.address = address;
		rq.phys_address = phys_address;
		rq.length = length;
		rq.flags = flags;
		command_queue.push_back(rq);
	endfunction

	function automatic region_request_t random_command();
		region_request_t rq;
		span_t pick;
		bit [31:0] origin;
		int roll;
		origin = ($urandom_range(0, 3) == 0) ? window_alt : window_origin;
		rq.command = art_pkg::CMD_FIND;
		rq.address = origin + ($urandom_range(0, 255) << art_pkg::PAGE_SHIFT);
		rq.phys_address = {$urandom, $urandom} & ~PAGE_BYTE_MASK;
		if ($urandom_range(0, 9) == 0)
			rq.length = $urandom_range(1, 4096) << art_pkg::PAGE_SHIFT;
		else
			rq.length = $urandom_range(1, 8) << art_pkg::PAGE_SHIFT;
		rq.flags = $urandom;
		if (mapped_spans.size() > 0) begin
			pick = mapped_spans[$urandom_range(0, mapped_spans.size() - 1)];
		end else begin
			pick.base_addr = rq.address;
			pick.span_len = rq.length;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			rq.command = art_pkg::cmd_t'($urandom_range(0, 3));
			rq.address = $urandom;
			rq.phys_address = {$urandom, $urandom};
			rq.length = $urandom;
			return rq;
		end
		if (roll < 40) begin
			rq.command = art_pkg::CMD_MAP;
			if ($urandom_range(0, 4) == 0) begin
				rq.address = pick.base_addr + ($urandom_range(0, 2) << art_pkg::PAGE_SHIFT);
				rq.length = pick.span_len;
			end
			mapped_spans.push_back('{rq.address, rq.length});
			if (mapped_spans.size() > 24)
				void'(mapped_spans.pop_front());
		end else if (roll < 75) begin
			rq.command = (roll < 60) ? art_pkg::CMD_UNMAP : art_pkg::CMD_PROTECT;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: begin
					rq.address = pick.base_addr;
					rq.length = pick.span_len;
				end
				7: begin
					rq.address = pick.base_addr;
					rq.length = (pick.span_len > 32'h1000) ? pick.span_len - 32'h1000
						: pick.span_len + 32'h1000;
				end
				8: begin
					rq.address = pick.base_addr + 32'h1000;
					rq.length = pick.span_len;
				end
				default: ;
			endcase
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: rq.address = pick.base_addr
					+ $urandom_range(0, pick.span_len - 1);
				6: rq.address = pick.base_addr + pick.span_len;
				7: rq.address = pick.base_addr - 32'd1;
				8: rq.address = $urandom;
				default: ;
			endcase
			return rq;
		end
		if ($urandom_range(0, 99) < 15) begin
			case ($urandom_range(0, 5))
				0: rq.length = '0;
				1: rq.address = rq.address | $urandom_range(1, 4095);
				2: rq.length = rq.length | $urandom_range(1, 4095);
				3: rq.phys_address = rq.phys_address | 64'($urandom_range(1, 4095));
				4: rq.address = model_user_base
					- ($urandom_range(1, 16) << art_pkg::PAGE_SHIFT);
				default: rq.phys_address = 64'hFFFF_FFFF_FFFF_F000
					- (64'($urandom_range(0, 7)) << art_pkg::PAGE_SHIFT);
			endcase
		end
		return rq;
	endfunction

	task automatic write_register(input logic [art_pkg::CFG_IDX_W-1:0] idx,
			input logic [art_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == art_pkg::REG_USER_BASE)
			model_user_base = value[31:0];
		else
			model_user_limit = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_and_settle();
		while (command_queue.size() != 0 || s_tvalid || awaited_replies.size() != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// sender side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				awaited_replies.push_back(apply_command(offered));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (command_queue.size() > 0) begin
					offered = command_queue.pop_front();
					s_tdata <= {6'b0, offered.flags, offered.length, offered.phys_address,
						offered.address, offered.command};
					s_tvalid <= 1'b1;
					if (!calm && $urandom_range(0, 99) < idle_pct)
						send_gap = $urandom_range(1, 15);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_replies.size() == 0) begin
					$error("reply transfer with none awaited: %h", m_tdata);
					mismatch_count++;
				end else begin
					oldest_reply = awaited_replies.pop_front();
					compare_field("status", 64'(oldest_reply.status), 64'(m_tdata[2:0]));
					compare_field("found", 64'(oldest_reply.found), 64'(m_tdata[3]));
					compare_field("region_base", 64'(oldest_reply.base), 64'(m_tdata[35:4]));
					compare_field("region_limit", 64'(oldest_reply.limit),
						64'(m_tdata[68:36]));
					compare_field("region_flags", 64'(oldest_reply.flags),
						64'(m_tdata[100:69]));
				end
				replies_seen++;
				if (replies_seen == 40 || replies_seen == 600)
					hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 4) begin
				stall_left = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// range checks, overlap, exact match and boundaries at the reset limits
		push_command(art_pkg::CMD_FIND, 32'h0040_0000, '0, 32'h1000, '0);
		push_command(art_pkg::CMD_MAP, 32'h0040_0000, '0, 32'h0, 32'h1);
		push_command(art_pkg::CMD_MAP, 32'h0040_0800, '0, 32'h1000, 32'h1);
		push_command(art_pkg::CMD_MAP, 32'h0040_0000, '0, 32'h1800, 32'h1);
		push_command(art_pkg::CMD_MAP, 32'h0040_0000, 64'h123, 32'h1000, 32'h1);
		push_command(art_pkg::CMD_MAP, 32'h003F_F000, '0, 32'h1000, 32'h1);
		push_command(art_pkg::CMD_MAP, 32'hC000_0000, '0, 32'h1000, 32'h1);
		push_command(art_pkg::CMD_MAP, 32'hBFFF_F000, '0, 32'h2000, 32'h1);
		push_command(art_pkg::CMD_MAP, 32'h0050_0000, 64'hFFFF_FFFF_FFFF_F000,
			32'h2000, 32'h1);
		push_command(art_pkg::CMD_MAP, 32'h0050_0000, 64'hFFFF_FFFF_FFFF_F000,
			32'h1000, 32'h0);
		push_command(art_pkg::CMD_MAP, 32'h0040_0000, '0, 32'h4000, 32'hFFFF_FFFF);
		push_command(art_pkg::CMD_MAP, 32'h0040_3000, '0, 32'h1000, 32'h2);
		push_command(art_pkg::CMD_FIND, 32'h0040_3FFF, '0, '0, '0);
		push_command(art_pkg::CMD_FIND, 32'h0040_4000, '0, '0, '0);
		push_command(art_pkg::CMD_PROTECT, 32'h0040_1000, '0, 32'h1000, 32'h5);
		push_command(art_pkg::CMD_PROTECT, 32'h0040_0000, '0, 32'h4000, 32'h0);
		push_command(art_pkg::CMD_FIND, 32'h0040_0000, '0, '0, '0);
		push_command(art_pkg::CMD_UNMAP, 32'h0080_0000, '0, 32'h1000, '0);
		push_command(art_pkg::CMD_UNMAP, 32'h0040_0000, '0, 32'h4000, '0);
		push_command(art_pkg::CMD_FIND, 32'h0040_2000, '0, '0, '0);
		push_command(art_pkg::CMD_MAP, 32'hBFFF_F000, 64'hFFFF_FFFF_FFFF_F000,
			32'h1000, 32'hA5A5_5A5A);
		push_command(art_pkg::CMD_FIND, 32'hBFFF_FFFF, '0, '0, '0);
		push_command(art_pkg::CMD_FIND, 32'hFFFF_FFFF, '0, '0, '0);
		push_command(art_pkg::CMD_UNMAP, 32'hBFFF_F000, '0, 32'h1000, '0);
		repeat (400) command_queue.push_back(random_command());
		drain_and_settle();

		// widest user space, up to the top of the virtual range
		write_register(art_pkg::REG_USER_BASE, 33'h0);
		write_register(art_pkg::REG_USER_LIMIT, 33'h1_0000_0000);
		window_origin = 32'h0000_0000;
		window_alt = 32'hFFF0_0000;
		repeat (400) command_queue.push_back(random_command());
		drain_and_settle();

		// inverted limits
		write_register(art_pkg::REG_USER_BASE, 33'h0_FFFF_FFFF);
		write_register(art_pkg::REG_USER_LIMIT, 33'h0);
		repeat (60) command_queue.push_back(random_command());
		drain_and_settle();

		write_register(art_pkg::REG_USER_BASE, 33'h0_1000_0000);
		write_register(art_pkg::REG_USER_LIMIT, 33'h0_2000_0000);
		window_origin = 32'h1000_0000;
		window_alt = 32'h1FF0_0000;
		idle_pct = 5;
		repeat (366) command_queue.push_back(random_command());
		drain_and_settle();

		write_register(art_pkg::REG_USER_BASE, 33'(art_pkg::USER_BASE_RST));
		write_register(art_pkg::REG_USER_LIMIT, art_pkg::USER_LIMIT_RST);
		window_origin = 32'h0040_0000;
		window_alt = 32'hBFF0_0000;
		calm = 1'b1;
		repeat (200) command_queue.push_back(random_command());
		drain_and_settle();

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
hdl/art_pkg.sv
hdl/art_ctrl.sv
hdl/art_dp.sv
hdl/address_region_table.sv
test/testbench.sv
